>>> rtl/ostp_pkg.sv
// ----------------------------------------------------------------------------
// One-shot timer pool package
// Shared field widths, command, kind and status codes, and the control
// struct for the remaining-count unit.
// ----------------------------------------------------------------------------
package ostp_pkg;

  localparam int DUR_W    = 16;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_DURATION = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE_SLOT  = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic load;
  } cnt_ctl_t;

endpackage

>>> rtl/ostp_count_unit.sv
// ----------------------------------------------------------------------------
// Remaining-count unit
// Holds the per-slot remaining counts in a memory with a registered read
// port and provides the shared decrementer and its zero detect.
// ----------------------------------------------------------------------------
module ostp_count_unit
  import ostp_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  cnt_ctl_t         ctl,
  input  logic [AW-1:0]    waddr,
  input  logic [AW-1:0]    raddr,
  input  logic [DUR_W-1:0] load_value,
  output logic             dec_zero
);

  logic [DUR_W-1:0] mem [DEPTH];
  logic [DUR_W-1:0] rd_data;
  logic [DUR_W-1:0] wr_data;
  logic [DUR_W-1:0] dec;

  assign dec      = rd_data - DUR_W'(1);
  assign dec_zero = (dec == '0);
  assign wr_data  = ctl.load ? load_value : dec;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

>>> rtl/one_shot_timer_pool.sv
// ----------------------------------------------------------------------------
// One-shot timer pool
// A pool of one-shot timers: start commands claim the lowest free slot and
// tick commands count every running slot down, reporting expiries in order.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, cmd, duration) takes one command per
// transaction. A start with a nonzero duration scans the slots from zero for
// the first free one, claims it and returns one reply; a zero duration or a
// full pool returns an error reply at once or after the scan. A tick walks all
// SLOT_COUNT slots through a two-stage read and decrement path on one shared
// count memory and returns one expiry transaction per slot that reaches zero,
// in ascending slot order, with last set on the final one; a tick that expires
// nothing returns no transaction.
// A start scans one slot per cycle and a tick walks the count memory one slot
// per cycle unless stalled. in_ready is high only while no command is in
// progress.
// Results leave through an output register, so a new command can be taken
// while the previous result waits. When the receiver stalls, the walk stops
// at the next result that cannot be placed and resumes once it drains.
// Reset frees every slot; the counts themselves are not cleared.
// ----------------------------------------------------------------------------
module one_shot_timer_pool
  import ostp_pkg::*;
#(
  parameter int SLOT_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [DUR_W-1:0]    duration,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [SLOT_W-1:0]   slot,
  output logic [STATUS_W-1:0] status,
  output logic                last
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [CW-1:0] END_CNT = CW'(SLOT_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_REPLY,
    ST_TICK,
    ST_FLUSH
  } state_t;

  state_t                state;
  logic [SLOT_COUNT-1:0] running;
  logic [CW-1:0]         cnt;
  logic [DUR_W-1:0]      dur_q;
  logic [SLOT_W-1:0]     rep_slot;
  logic [STATUS_W-1:0]   rep_status;
  logic                  s2_valid;
  logic                  s2_run;
  logic [AW-1:0]         s2_idx;
  logic                  pend_valid;
  logic [SLOT_W-1:0]     pend_slot;

  logic [AW-1:0]   cnt_idx;
  logic [AW+4:0]   cnt_ext;
  logic [AW+4:0]   s2_ext;
  logic            scan_more;
  logic            out_free;
  logic            expire;
  logic            stall;
  logic            claim;
  cnt_ctl_t        ctl;
  logic [AW-1:0]   waddr;
  logic            dec_zero;

  assign cnt_idx   = cnt[AW-1:0];
  assign cnt_ext   = {5'd0, cnt_idx};
  assign s2_ext    = {5'd0, s2_idx};
  assign scan_more = (cnt < END_CNT);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  assign expire = (state == ST_TICK) && s2_valid && s2_run && dec_zero;
  assign stall  = expire && pend_valid && !out_free;
  assign claim  = (state == ST_FIND) && scan_more && !running[cnt_idx];

  assign ctl.load  = (state == ST_FIND);
  assign ctl.wr_en = claim || ((state == ST_TICK) && s2_valid && s2_run && !stall);
  assign ctl.rd_en = (state == ST_TICK) && scan_more && !stall;
  assign waddr     = (state == ST_FIND) ? cnt_idx : s2_idx;

  ostp_count_unit #(
    .DEPTH(SLOT_COUNT),
    .AW   (AW)
  ) u_count (
    .clk       (clk),
    .ctl       (ctl),
    .waddr     (waddr),
    .raddr     (cnt_idx),
    .load_value(dur_q),
    .dec_zero  (dec_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      running    <= '0;
      cnt        <= '0;
      s2_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            dur_q      <= duration;
            cnt        <= '0;
            s2_valid   <= 1'b0;
            pend_valid <= 1'b0;
            if (cmd == CMD_START) begin
              if (duration == '0) begin
                rep_slot   <= '0;
                rep_status <= STATUS_ZERO_DURATION;
                state      <= ST_REPLY;
              end else begin
                state <= ST_FIND;
              end
            end else begin
              state <= ST_TICK;
            end
          end
        end
        ST_FIND: begin
          if (!scan_more) begin
            rep_slot   <= '0;
            rep_status <= STATUS_NO_FREE_SLOT;
            state      <= ST_REPLY;
          end else if (!running[cnt_idx]) begin
            running[cnt_idx] <= 1'b1;
            rep_slot         <= cnt_ext[4:0];
            rep_status       <= STATUS_OK;
            state            <= ST_REPLY;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_REPLY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            kind      <= KIND_REPLY;
            slot      <= rep_slot;
            status    <= rep_status;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_TICK: begin
          if (!stall) begin
            if (scan_more) begin
              s2_valid <= 1'b1;
              s2_idx   <= cnt_idx;
              s2_run   <= running[cnt_idx];
              cnt      <= cnt + CW'(1);
            end else begin
              s2_valid <= 1'b0;
            end
            if (expire) begin
              running[s2_idx] <= 1'b0;
              pend_slot       <= s2_ext[4:0];
              pend_valid      <= 1'b1;
              if (pend_valid) begin
                out_valid <= 1'b1;
                kind      <= KIND_EXPIRY;
                slot      <= pend_slot;
                status    <= STATUS_OK;
                last      <= 1'b0;
              end
            end
            if (!scan_more && !s2_valid) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            kind       <= KIND_EXPIRY;
            slot       <= pend_slot;
            status     <= STATUS_OK;
            last       <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("Expiry left pending after the tick finished.");

  a_expiry_status_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_EXPIRY)) |-> (status == STATUS_OK))
    else $error("Expiry transaction carries a nonzero status.");

  a_reply_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_REPLY)) |-> last)
    else $error("Start reply is not marked as the final transaction.");

  a_flush_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> !s2_valid)
    else $error("Slot still in the decrement stage after the walk ended.");

endmodule
